>>> hw/rtl/ucp_pkg.sv
// types, character codes and scheme tables for the url component parser
`default_nettype none

package ucp_pkg;

   // input word: one url character
   typedef struct packed {
      logic [7:0] url_byte;
      logic       last_byte;
   } ucp_req_type;

   // result word: one per url
   typedef struct packed {
      logic [1:0]  status;
      logic [12:0] scheme_len;
      logic [12:0] user_len;
      logic [12:0] host_start;
      logic [12:0] host_len;
      logic [12:0] port_len;
      logic [12:0] path_start;
      logic [12:0] path_len;
      logic [12:0] args_len;
      logic [12:0] fragment_len;
      logic [15:0] port_number;
   } ucp_rsp_type;

   // parse phase
   typedef enum logic [2:0] {
      PH_SCHEME = 3'd0,
      PH_AUTH   = 3'd1,
      PH_PATH   = 3'd2,
      PH_ARGS   = 3'd3,
      PH_FRAG   = 3'd4
   } ucp_phase_type;

   // status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_BAD  = 2'd1;
   localparam logic [1:0] ST_LONG = 2'd2;

   // separator characters
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_AT    = 8'h40;
   localparam logic [7:0] CH_QUEST = 8'h3F;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // port limits
   localparam logic [16:0] PORT_MAX = 17'd65535;
   localparam logic [16:0] PORT_SAT = 17'd65536;

   // known schemes: http, https, rtmp
   localparam int NUM_NAMES = 3;
   localparam logic [7:0] NAME_TEXT [3][5] = '{
      '{8'h68, 8'h74, 8'h74, 8'h70, 8'h00},
      '{8'h68, 8'h74, 8'h74, 8'h70, 8'h73},
      '{8'h72, 8'h74, 8'h6D, 8'h70, 8'h00}
   };
   localparam logic [2:0]  NAME_LEN  [3] = '{3'd4, 3'd5, 3'd4};
   localparam logic [15:0] NAME_PORT [3] = '{16'd80, 16'd443, 16'd1935};

   // does character c at small offset p keep scheme k alive
   function automatic logic name_char_ok(input logic [1:0] k, input logic [7:0] c,
                                         input logic [2:0] p);
      logic ok;
      ok = 1'b1;
      if (p < NAME_LEN[k]) begin
         ok = (c == NAME_TEXT[k][p]);
      end else if (p == NAME_LEN[k]) begin
         ok = (c == CH_COLON);
      end
      return ok;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/url_component_parser_unit.sv
// url component parser: splits a byte stream url into its parts, one result per url
//
//   channel | direction | word               | handshake
//   req_    | in        | url_byte,last_byte | req_valid / req_stall
//   rsp_    | out       | status,lengths,port| rsp_valid / rsp_stall
//
// one character per clock while no final character is held by a stall; a word goes input register ->
// parse logic -> result register, so a result is held in both registers in turn after its last character is taken.
// the parse state updates in the same cycle the character leaves the input register.
// a non-final character never waits on rsp_stall; a final one waits only while the
// result register holds an untaken word.
// reset is synchronous, active high, and clears the parse state and both valid flags.
`default_nettype none

module url_component_parser_unit #(
   parameter int MAX_LEN = 4096
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  wire ucp_pkg::ucp_req_type req_word,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output ucp_pkg::ucp_rsp_type      rsp_word
);

   localparam int PW = $clog2(MAX_LEN + 1);

   // input register
   logic                 req_valid_ff;
   ucp_pkg::ucp_req_type req_word_ff;

   // result register
   logic                 rsp_valid_ff;
   ucp_pkg::ucp_rsp_type rsp_word_ff;
   ucp_pkg::ucp_rsp_type rsp_word_in;

   // parse state
   ucp_pkg::ucp_phase_type phase_ff, phase_in;
   logic [1:0]    sep_ff, sep_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [PW-1:0] mk_scheme_ff, mk_scheme_in;
   logic [PW-1:0] mk_auth_ff, mk_auth_in;
   logic [PW-1:0] mk_at_ff, mk_at_in;
   logic [PW-1:0] mk_colon_ff, mk_colon_in;
   logic [PW-1:0] mk_slash_ff, mk_slash_in;
   logic [PW-1:0] mk_quest_ff, mk_quest_in;
   logic [PW-1:0] mk_hash_ff, mk_hash_in;
   logic          at_seen_ff, at_seen_in;
   logic          colon_seen_ff, colon_seen_in;
   logic          too_long_ff, too_long_in;
   logic [16:0]   port_acc_ff, port_acc_in;
   logic          port_bad_ff, port_bad_in;
   logic [2:0]    name_match_ff, name_match_in;

   logic          out_free;
   logic          advance;
   logic [7:0]    ch;
   logic [19:0]   acc_wide;

   // handshake
   assign ch        = req_word_ff.url_byte;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = req_valid_ff && (!req_word_ff.last_byte || out_free);
   assign req_stall = req_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // decimal port digit step
   assign acc_wide = ({3'b000, port_acc_ff} << 3) + ({3'b000, port_acc_ff} << 1)
                   + 20'(ch - ucp_pkg::CH_ZERO);

   // next parse state for the character in the input register
   always_comb begin
      phase_in      = phase_ff;
      sep_in        = sep_ff;
      pos_in        = pos_ff;
      mk_scheme_in  = mk_scheme_ff;
      mk_auth_in    = mk_auth_ff;
      mk_at_in      = mk_at_ff;
      mk_colon_in   = mk_colon_ff;
      mk_slash_in   = mk_slash_ff;
      mk_quest_in   = mk_quest_ff;
      mk_hash_in    = mk_hash_ff;
      at_seen_in    = at_seen_ff;
      colon_seen_in = colon_seen_ff;
      too_long_in   = too_long_ff;
      port_acc_in   = port_acc_ff;
      port_bad_in   = port_bad_ff;
      name_match_in = name_match_ff;
      if (pos_ff >= PW'(MAX_LEN)) begin
         too_long_in = 1'b1;
      end else begin
         pos_in = pos_ff + PW'(1);
         case (phase_ff)
            ucp_pkg::PH_SCHEME: begin
               // known scheme names, checked over the first few characters
               if (pos_ff < PW'(8)) begin
                  for (int k = 0; k < ucp_pkg::NUM_NAMES; k++) begin
                     if (!ucp_pkg::name_char_ok(2'(k), ch, pos_ff[2:0])) begin
                        name_match_in[k] = 1'b0;
                     end
                  end
               end
               // look for "://"
               if (sep_ff == 2'd2 && ch == ucp_pkg::CH_SLASH) begin
                  mk_scheme_in = pos_ff - PW'(2);
                  mk_auth_in   = pos_ff + PW'(1);
                  for (int k = 0; k < ucp_pkg::NUM_NAMES; k++) begin
                     if (PW'(ucp_pkg::NAME_LEN[k]) != pos_ff - PW'(2)) begin
                        name_match_in[k] = 1'b0;
                     end
                  end
                  sep_in   = 2'd0;
                  phase_in = ucp_pkg::PH_AUTH;
               end else if (sep_ff == 2'd1 && ch == ucp_pkg::CH_SLASH) begin
                  sep_in = 2'd2;
               end else begin
                  sep_in = (ch == ucp_pkg::CH_COLON) ? 2'd1 : 2'd0;
               end
            end
            ucp_pkg::PH_AUTH: begin
               if (ch == ucp_pkg::CH_SLASH) begin
                  mk_slash_in = pos_ff;
                  phase_in    = ucp_pkg::PH_PATH;
               end else if (ch == ucp_pkg::CH_AT && !at_seen_ff) begin
                  at_seen_in    = 1'b1;
                  colon_seen_in = 1'b0;
                  mk_at_in      = pos_ff;
                  port_acc_in   = '0;
                  port_bad_in   = 1'b0;
               end else if (ch == ucp_pkg::CH_COLON && !colon_seen_ff) begin
                  colon_seen_in = 1'b1;
                  mk_colon_in   = pos_ff;
                  port_acc_in   = '0;
                  port_bad_in   = 1'b0;
               end else if (colon_seen_ff) begin
                  // port digits, saturating just above the largest port
                  if (ch >= ucp_pkg::CH_ZERO && ch <= ucp_pkg::CH_NINE) begin
                     port_acc_in = (acc_wide > 20'(ucp_pkg::PORT_SAT)) ?
                                   ucp_pkg::PORT_SAT : acc_wide[16:0];
                  end else begin
                     port_bad_in = 1'b1;
                  end
               end
            end
            ucp_pkg::PH_PATH: begin
               if (ch == ucp_pkg::CH_QUEST) begin
                  mk_quest_in = pos_ff;
                  phase_in    = ucp_pkg::PH_ARGS;
               end
            end
            ucp_pkg::PH_ARGS: begin
               if (ch == ucp_pkg::CH_HASH) begin
                  mk_hash_in = pos_ff;
                  phase_in   = ucp_pkg::PH_FRAG;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // result word from the updated state
   logic [PW-1:0] host, auth_end, port_beg, path_beg, args_beg, frag_beg, port_len_w;
   logic          in_path, path_there, bad;

   always_comb begin
      rsp_word_in = '0;
      in_path     = phase_in inside {ucp_pkg::PH_PATH, ucp_pkg::PH_ARGS, ucp_pkg::PH_FRAG};
      auth_end    = in_path ? mk_slash_in : pos_in;
      host        = at_seen_in ? mk_at_in + PW'(1) : mk_auth_in;
      port_beg    = mk_colon_in + PW'(1);
      path_beg    = mk_slash_in + PW'(1);
      args_beg    = mk_quest_in + PW'(1);
      frag_beg    = mk_hash_in + PW'(1);
      path_there  = in_path && (path_beg < pos_in);
      port_len_w  = colon_seen_in ? auth_end - port_beg : '0;
      bad = (phase_in == ucp_pkg::PH_SCHEME)
         || (mk_auth_in >= pos_in)
         || (at_seen_in && (mk_at_in == mk_auth_in || host == auth_end))
         || (colon_seen_in && port_beg == auth_end)
         || (path_there && (phase_in == ucp_pkg::PH_ARGS || phase_in == ucp_pkg::PH_FRAG)
             && args_beg == pos_in)
         || (path_there && phase_in == ucp_pkg::PH_FRAG && frag_beg == pos_in);
      if (too_long_in) begin
         rsp_word_in.status = ucp_pkg::ST_LONG;
      end else if (bad) begin
         rsp_word_in.status = ucp_pkg::ST_BAD;
      end else begin
         rsp_word_in.status     = ucp_pkg::ST_OK;
         rsp_word_in.scheme_len = 13'(mk_scheme_in);
         rsp_word_in.user_len   = at_seen_in ? 13'(mk_at_in - mk_auth_in) : 13'd0;
         rsp_word_in.host_start = 13'(host);
         rsp_word_in.host_len   = colon_seen_in ? 13'(mk_colon_in - host)
                                                : 13'(auth_end - host);
         rsp_word_in.port_len   = 13'(port_len_w);
         // path, args and fragment
         if (path_there) begin
            rsp_word_in.path_start = 13'(path_beg);
            case (phase_in)
               ucp_pkg::PH_PATH: begin
                  rsp_word_in.path_len = 13'(pos_in - path_beg);
               end
               ucp_pkg::PH_ARGS: begin
                  rsp_word_in.path_len = 13'(mk_quest_in - path_beg);
                  rsp_word_in.args_len = 13'(pos_in - args_beg);
               end
               default: begin
                  rsp_word_in.path_len     = 13'(mk_quest_in - path_beg);
                  rsp_word_in.args_len     = 13'(mk_hash_in - args_beg);
                  rsp_word_in.fragment_len = 13'(pos_in - frag_beg);
               end
            endcase
         end
         // explicit port, else scheme default
         if (port_len_w != '0) begin
            if (!port_bad_in && port_acc_in != '0 && port_acc_in <= ucp_pkg::PORT_MAX) begin
               rsp_word_in.port_number = port_acc_in[15:0];
            end
         end else if (name_match_in[0]) begin
            rsp_word_in.port_number = ucp_pkg::NAME_PORT[0];
         end else if (name_match_in[1]) begin
            rsp_word_in.port_number = ucp_pkg::NAME_PORT[1];
         end else if (name_match_in[2]) begin
            rsp_word_in.port_number = ucp_pkg::NAME_PORT[2];
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
      if (!req_stall && req_valid) begin
         req_word_ff <= req_word;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && req_word_ff.last_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance && req_word_ff.last_byte) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // parse state, cleared after each url
   always_ff @(posedge clock) begin
      if (reset || (advance && req_word_ff.last_byte)) begin
         phase_ff      <= ucp_pkg::PH_SCHEME;
         sep_ff        <= '0;
         pos_ff        <= '0;
         mk_scheme_ff  <= '0;
         mk_auth_ff    <= '0;
         mk_at_ff      <= '0;
         mk_colon_ff   <= '0;
         mk_slash_ff   <= '0;
         mk_quest_ff   <= '0;
         mk_hash_ff    <= '0;
         at_seen_ff    <= 1'b0;
         colon_seen_ff <= 1'b0;
         too_long_ff   <= 1'b0;
         port_acc_ff   <= '0;
         port_bad_ff   <= 1'b0;
         name_match_ff <= '1;
      end else if (advance) begin
         phase_ff      <= phase_in;
         sep_ff        <= sep_in;
         pos_ff        <= pos_in;
         mk_scheme_ff  <= mk_scheme_in;
         mk_auth_ff    <= mk_auth_in;
         mk_at_ff      <= mk_at_in;
         mk_colon_ff   <= mk_colon_in;
         mk_slash_ff   <= mk_slash_in;
         mk_quest_ff   <= mk_quest_in;
         mk_hash_ff    <= mk_hash_in;
         at_seen_ff    <= at_seen_in;
         colon_seen_ff <= colon_seen_in;
         too_long_ff   <= too_long_in;
         port_acc_ff   <= port_acc_in;
         port_bad_ff   <= port_bad_in;
         name_match_ff <= name_match_in;
      end
   end

endmodule

`default_nettype wire
